// ===== sv/wspq_pkg.sv =====
// ----------------------------------------------------------------------------
// wspq_pkg: shared types and constants of the weighted score priority queue
// Request and status codes, field widths and the classified request record.
// ----------------------------------------------------------------------------
package wspq_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int GRADE_CAP_DEF  = 10;
  localparam int COURSE_CAP_DEF = 32;

  localparam int PAYLOAD_W = 32;
  localparam int GRADE_W   = 10;
  localparam int COURSE_W  = 6;
  localparam int PRIO_W    = 17;

  localparam logic [1:0] REQ_ENQ   = 2'd0;
  localparam logic [1:0] REQ_DEQ   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] OP_ENQ   = 2'd0;
  localparam logic [1:0] OP_DEQ   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]           op;
    logic [PAYLOAD_W-1:0] payload;
    logic [GRADE_W-1:0]   grade;
    logic [COURSE_W-1:0]  courses;
    logic [PRIO_W-1:0]    prio;
  } cmd_t;

endpackage

// ===== sv/weighted_score_priority_queue.sv =====
// ----------------------------------------------------------------------------
// weighted_score_priority_queue: bounded priority queue, top level
// Classifier, command queue and sorted shift-register store.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per transaction: enqueue, dequeue or query.
//   m_axis returns exactly one result per request: head fields, entry count,
//   empty flag and status (full enqueue dropped, empty dequeue ignored).
//   From input transaction to result valid a request passes two
//   classifier stages (clamp, then constant divide for the Q2.15 priority),
//   the command queue, and the store update whose head is shown from the
//   result register. Throughput is one request per cycle while the receiver
//   takes results, set by the parallel compare-and-shift of the slot array.
//   Reset clears all valid flags and the entry count; slot contents are
//   left as they are and never read before being written.
//   When the receiver stalls, the result holds, the store stops taking
//   commands, the two-entry queue and the classifier fill, s_axis_tready drops.
// ----------------------------------------------------------------------------
module weighted_score_priority_queue #(
  parameter int CAPACITY   = wspq_pkg::CAPACITY_DEF,
  parameter int GRADE_CAP  = wspq_pkg::GRADE_CAP_DEF,
  parameter int COURSE_CAP = wspq_pkg::COURSE_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // payload[31:0], grade_x100[41:32], courses_passed[47:42]
  input  logic [47:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // head_payload[31:0], head_grade_x100[41:32], head_courses[47:42],
  // head_priority[64:48], entry_count[71:65], is_empty[72], zero fill
  output logic [((65 + $clog2(CAPACITY+1) + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int OUT_W = ((65 + CNT_W + 1 + 7) / 8) * 8;

  logic                           f_valid;
  logic                           f_ready;
  wspq_pkg::cmd_t                 f_cmd;
  logic                           q_valid;
  logic                           q_ready;
  wspq_pkg::cmd_t                 q_cmd;
  logic [wspq_pkg::PAYLOAD_W-1:0] h_pay;
  logic [wspq_pkg::GRADE_W-1:0]   h_grd;
  logic [wspq_pkg::COURSE_W-1:0]  h_crs;
  logic [wspq_pkg::PRIO_W-1:0]    h_pri;
  logic [CNT_W-1:0]               h_cnt;
  logic                           h_empty;

  wspq_front #(
    .GRADE_CAP  (GRADE_CAP),
    .COURSE_CAP (COURSE_CAP)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .req_type       (s_axis_tuser),
    .payload        (s_axis_tdata[31:0]),
    .grade_x100     (s_axis_tdata[41:32]),
    .courses_passed (s_axis_tdata[47:42]),
    .cmd_valid      (f_valid),
    .cmd_ready      (f_ready),
    .cmd            (f_cmd)
  );

  wspq_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  wspq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (q_valid),
    .cmd_ready       (q_ready),
    .cmd             (q_cmd),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .head_payload    (h_pay),
    .head_grade_x100 (h_grd),
    .head_courses    (h_crs),
    .head_priority   (h_pri),
    .entry_count     (h_cnt),
    .is_empty        (h_empty),
    .status          (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_W'({h_empty, h_cnt, h_pri, h_crs, h_grd, h_pay});

endmodule

// ===== sv/wspq_front.sv =====
// ----------------------------------------------------------------------------
// wspq_front: request classifier
// Clamps grade and course count, computes the Q2.15 priority and registers
// one classified command.
// ----------------------------------------------------------------------------
module wspq_front #(
  parameter int GRADE_CAP  = wspq_pkg::GRADE_CAP_DEF,
  parameter int COURSE_CAP = wspq_pkg::COURSE_CAP_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    req_type,
  input  logic [wspq_pkg::PAYLOAD_W-1:0] payload,
  input  logic [wspq_pkg::GRADE_W-1:0]  grade_x100,
  input  logic [wspq_pkg::COURSE_W-1:0] courses_passed,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output wspq_pkg::cmd_t                cmd
);

  localparam int GMAX  = 100 * GRADE_CAP;
  localparam int DEN   = GMAX * COURSE_CAP;
  localparam int NUM_W = $clog2(2 * DEN + 1) + 1;
  localparam int MUL_W = NUM_W + 16;
  // reciprocal for floor(num*32768/DEN)
  localparam int SH    = MUL_W + 2;
  localparam longint RECIP = ((longint'(1) <<< SH) + DEN - 1) / DEN;

  // stage 1: clamp and form numerator
  logic                           s1_valid;
  logic [1:0]                     s1_op;
  logic [wspq_pkg::PAYLOAD_W-1:0] s1_payload;
  logic [wspq_pkg::GRADE_W-1:0]   s1_grade;
  logic [wspq_pkg::COURSE_W-1:0]  s1_courses;
  logic [NUM_W-1:0]               s1_num;
  logic [wspq_pkg::GRADE_W-1:0]   g_cl;
  logic [wspq_pkg::COURSE_W-1:0]  c_cl;
  logic [1:0]                     op_cl;
  logic                           s1_ready;
  logic [MUL_W-1:0]               scaled;
  logic [MUL_W+SH-1:0]            prod;
  logic [MUL_W:0]                 quot;
  logic [MUL_W+1:0]               rem_chk;

  assign s1_ready = !cmd_valid || cmd_ready;
  assign in_ready = !s1_valid || s1_ready;

  always_comb begin
    g_cl = (32'(grade_x100) > GMAX) ? wspq_pkg::GRADE_W'(GMAX) : grade_x100;
    c_cl = (32'(courses_passed) > COURSE_CAP) ?
           wspq_pkg::COURSE_W'(COURSE_CAP) : courses_passed;
    case (req_type)
      wspq_pkg::REQ_ENQ: op_cl = wspq_pkg::OP_ENQ;
      wspq_pkg::REQ_DEQ: op_cl = wspq_pkg::OP_DEQ;
      default:           op_cl = wspq_pkg::OP_QUERY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_op      <= op_cl;
      s1_payload <= payload;
      s1_grade   <= g_cl;
      s1_courses <= c_cl;
      s1_num     <= NUM_W'(g_cl * COURSE_CAP + c_cl * GMAX);
    end
  end

  // stage 2: constant divide by reciprocal with one correction step
  always_comb begin
    scaled  = MUL_W'({s1_num, 15'd0});
    prod    = (MUL_W+SH)'(scaled) * (MUL_W+SH)'(RECIP);
    quot    = (MUL_W+1)'(prod >> SH);
    rem_chk = (MUL_W+2)'(scaled) - (MUL_W+2)'(quot * DEN);
    if (rem_chk[MUL_W+1]) begin
      quot = quot - 1'b1;
    end else if (rem_chk >= (MUL_W+2)'(DEN)) begin
      quot = quot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s1_ready) begin
      cmd_valid <= s1_valid;
    end
    if (s1_ready && s1_valid) begin
      cmd.op      <= s1_op;
      cmd.payload <= s1_payload;
      cmd.grade   <= s1_grade;
      cmd.courses <= s1_courses;
      cmd.prio    <= wspq_pkg::PRIO_W'(quot);
    end
  end

endmodule

// ===== sv/wspq_fifo.sv =====
// ----------------------------------------------------------------------------
// wspq_fifo: command queue between classifier and sorted store
// Two-entry queue so each side can stall on its own.
// ----------------------------------------------------------------------------
module wspq_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  wspq_pkg::cmd_t wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output wspq_pkg::cmd_t rd_cmd
);

  wspq_pkg::cmd_t mem [2];
  logic           wp;
  logic           rp;
  logic [1:0]     fill;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_cmd   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      fill <= fill + 2'((wr_valid && wr_ready)) - 2'((rd_valid && rd_ready));
    end
    if (wr_valid && wr_ready) mem[wp] <= wr_cmd;
  end

endmodule

// ===== sv/wspq_back.sv =====
// ----------------------------------------------------------------------------
// wspq_back: sorted shift-register store
// Every slot compares against the new priority in parallel; enqueue shifts
// the tail down one slot, dequeue shifts everything up one slot.
// ----------------------------------------------------------------------------
module wspq_back #(
  parameter int CAPACITY = wspq_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  wspq_pkg::cmd_t                 cmd,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [wspq_pkg::PAYLOAD_W-1:0] head_payload,
  output logic [wspq_pkg::GRADE_W-1:0]   head_grade_x100,
  output logic [wspq_pkg::COURSE_W-1:0]  head_courses,
  output logic [wspq_pkg::PRIO_W-1:0]    head_priority,
  output logic [$clog2(CAPACITY+1)-1:0]  entry_count,
  output logic                           is_empty,
  output logic [1:0]                     status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [wspq_pkg::PAYLOAD_W-1:0] s_pay  [CAPACITY];
  logic [wspq_pkg::GRADE_W-1:0]   s_grd  [CAPACITY];
  logic [wspq_pkg::COURSE_W-1:0]  s_crs  [CAPACITY];
  logic [wspq_pkg::PRIO_W-1:0]    s_pri  [CAPACITY];
  logic [CNT_W-1:0]               count;
  logic [CNT_W-1:0]               count_next;
  logic [CAPACITY-1:0]            keep;
  logic                           fire;
  logic                           do_enq;
  logic                           do_deq;
  logic [1:0]                     st;

  assign cmd_ready = !out_valid || out_ready;
  assign fire      = cmd_valid && cmd_ready;

  // per-slot: stays ahead of the new entry
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      keep[i] = (CNT_W'(i) < count) && (s_pri[i] >= cmd.prio);
    end
    do_enq     = 1'b0;
    do_deq     = 1'b0;
    st         = wspq_pkg::ST_OK;
    count_next = count;
    case (cmd.op)
      wspq_pkg::OP_ENQ: begin
        if (count == CNT_W'(CAPACITY)) begin
          st = wspq_pkg::ST_FULL;
        end else begin
          do_enq     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      wspq_pkg::OP_DEQ: begin
        if (count == '0) begin
          st = wspq_pkg::ST_EMPTY;
        end else begin
          do_deq     = 1'b1;
          count_next = count - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // slot array update
  always_ff @(posedge clk) begin
    if (fire && do_enq) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (!keep[i]) begin
          if (i == 0 || keep[(i == 0) ? 0 : i-1]) begin
            s_pay[i] <= cmd.payload;
            s_grd[i] <= cmd.grade;
            s_crs[i] <= cmd.courses;
            s_pri[i] <= cmd.prio;
          end else begin
            s_pay[i] <= s_pay[(i == 0) ? 0 : i-1];
            s_grd[i] <= s_grd[(i == 0) ? 0 : i-1];
            s_crs[i] <= s_crs[(i == 0) ? 0 : i-1];
            s_pri[i] <= s_pri[(i == 0) ? 0 : i-1];
          end
        end
      end
    end else if (fire && do_deq) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        s_pay[i] <= s_pay[i+1];
        s_grd[i] <= s_grd[i+1];
        s_crs[i] <= s_crs[i+1];
        s_pri[i] <= s_pri[i+1];
      end
    end
  end

  // count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) count <= count_next;
      if (cmd_ready) out_valid <= cmd_valid;
    end
    if (fire) begin
      status <= st;
    end
  end

  // head view follows the stored state after the transaction
  always_comb begin
    is_empty    = (count == '0);
    entry_count = count;
    if (is_empty) begin
      head_payload    = '0;
      head_grade_x100 = '0;
      head_courses    = '0;
      head_priority   = '0;
    end else begin
      head_payload    = s_pay[0];
      head_grade_x100 = s_grd[0];
      head_courses    = s_crs[0];
      head_priority   = s_pri[0];
    end
  end

endmodule

// ===== dv/wspq_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wspq_checker: result checker for the weighted score priority queue
// Watches both stream channels, keeps a sorted shadow of the queue, predicts
// one result per accepted request and compares each returned result with it.
// ----------------------------------------------------------------------------
module wspq_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          fail_count,
  output int          pending
);

  localparam int GMAX  = 100 * wspq_pkg::GRADE_CAP_DEF;
  localparam int CCAP  = wspq_pkg::COURSE_CAP_DEF;
  localparam int DEPTH = wspq_pkg::CAPACITY_DEF;

  typedef struct packed {
    logic [wspq_pkg::PAYLOAD_W-1:0] payload;
    logic [wspq_pkg::GRADE_W-1:0]   grade;
    logic [wspq_pkg::COURSE_W-1:0]  courses;
    logic [wspq_pkg::PRIO_W-1:0]    prio;
    logic [6:0]                     count;
    logic                           empty;
    logic [1:0]                     status;
  } head_rpt_t;

  // shadow of the sorted store
  logic [wspq_pkg::PAYLOAD_W-1:0] sh_payload [DEPTH];
  logic [wspq_pkg::GRADE_W-1:0]   sh_grade   [DEPTH];
  logic [wspq_pkg::COURSE_W-1:0]  sh_courses [DEPTH];
  logic [wspq_pkg::PRIO_W-1:0]    sh_prio    [DEPTH];
  int                             sh_count;
  head_rpt_t                      head_rpts_due [$];

  // Q2.15 priority, truncated
  function automatic logic [wspq_pkg::PRIO_W-1:0] score_q16(int unsigned g,
                                                             int unsigned c);
    longint unsigned num;
    num = longint'(g) * CCAP + longint'(c) * GMAX;
    return wspq_pkg::PRIO_W'((num * 32768) / (GMAX * CCAP));
  endfunction

  // apply one request to the shadow and return the expected report
  function automatic head_rpt_t apply_request(logic [1:0] req, logic [47:0] d);
    head_rpt_t r;
    int unsigned g;
    int unsigned c;
    logic [wspq_pkg::PRIO_W-1:0] p;
    int pos;
    r = '0;
    r.status = wspq_pkg::ST_OK;
    if (req == wspq_pkg::REQ_ENQ) begin
      if (sh_count >= DEPTH) begin
        r.status = wspq_pkg::ST_FULL;
      end else begin
        g = d[41:32];
        c = d[47:42];
        if (g > GMAX) g = GMAX;
        if (c > CCAP) c = CCAP;
        p = score_q16(g, c);
        pos = 0;
        while (pos < sh_count && sh_prio[pos] >= p) pos++;
        for (int k = sh_count; k > pos; k--) begin
          sh_payload[k] = sh_payload[k-1];
          sh_grade[k]   = sh_grade[k-1];
          sh_courses[k] = sh_courses[k-1];
          sh_prio[k]    = sh_prio[k-1];
        end
        sh_payload[pos] = d[31:0];
        sh_grade[pos]   = wspq_pkg::GRADE_W'(g);
        sh_courses[pos] = wspq_pkg::COURSE_W'(c);
        sh_prio[pos]    = p;
        sh_count++;
      end
    end else if (req == wspq_pkg::REQ_DEQ) begin
      if (sh_count == 0) begin
        r.status = wspq_pkg::ST_EMPTY;
      end else begin
        for (int k = 1; k < sh_count; k++) begin
          sh_payload[k-1] = sh_payload[k];
          sh_grade[k-1]   = sh_grade[k];
          sh_courses[k-1] = sh_courses[k];
          sh_prio[k-1]    = sh_prio[k];
        end
        sh_count--;
      end
    end
    // query and the unused code leave the store alone
    if (sh_count != 0) begin
      r.payload = sh_payload[0];
      r.grade   = sh_grade[0];
      r.courses = sh_courses[0];
      r.prio    = sh_prio[0];
    end
    r.count = 7'(sh_count);
    r.empty = (sh_count == 0);
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  assign pending = head_rpts_due.size();

  always @(posedge clk) begin
    head_rpt_t e;
    if (rst) begin
      sh_count   = 0;
      fail_count = 0;
      head_rpts_due.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        head_rpts_due.push_back(apply_request(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (head_rpts_due.size() == 0) begin
          $display("%0t: unexpected result transaction, actual %0h/%0h",
                   $time, m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          e = head_rpts_due.pop_front();
          check_field("head_payload", e.payload, m_axis_tdata[31:0]);
          check_field("head_grade_x100", e.grade, m_axis_tdata[41:32]);
          check_field("head_courses", e.courses, m_axis_tdata[47:42]);
          check_field("head_priority", e.prio, m_axis_tdata[64:48]);
          check_field("entry_count", e.count, m_axis_tdata[71:65]);
          check_field("is_empty", e.empty, m_axis_tdata[72]);
          check_field("status", e.status, m_axis_tuser);
        end
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the weighted score priority queue
// Directed corner requests, then random fill and drain phases with bursty
// input and a stalling receiver; results are checked by wspq_checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = wspq_pkg::REQ_QUERY;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          burst_left = 0;

  always #10 clk = ~clk;

  weighted_score_priority_queue uut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  wspq_checker chk (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count, .pending
  );

  // receiver: alternating windows of always-ready and random stalls
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles[8])
      m_axis_tready <= ($urandom_range(0, 9) < 6);
    else
      m_axis_tready <= 1'b1;
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one request transaction, with random gaps between bursts
  task automatic send_req(logic [1:0] req, logic [31:0] pay, logic [9:0] grade,
                          logic [5:0] crs);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {crs, grade, pay};
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    burst_left--;
  endtask

  task automatic idle_sender();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  // random request; enq_pct biases toward filling or draining
  task automatic rand_req(int enq_pct);
    logic [1:0] req;
    logic [9:0] g;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < enq_pct) req = wspq_pkg::REQ_ENQ;
    else if (roll < 92) req = wspq_pkg::REQ_DEQ;
    else req = $urandom_range(0, 1) ? wspq_pkg::REQ_QUERY : wspq_pkg::REQ_RSVD;
    // a handful of grades makes ties common
    g = $urandom_range(0, 2) == 0 ? 10'(100 * $urandom_range(0, 10))
                                  : 10'($urandom_range(0, 1023));
    send_req(req, $urandom, g, 6'($urandom_range(0, 63)));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty queue, extremes, clamping, unused code
    send_req(wspq_pkg::REQ_QUERY, '0, '0, '0);
    send_req(wspq_pkg::REQ_DEQ, '0, '0, '0);
    send_req(wspq_pkg::REQ_ENQ, 32'h0000_0000, 10'd0, 6'd0);
    send_req(wspq_pkg::REQ_ENQ, 32'hFFFF_FFFF, 10'd1000, 6'd32);
    send_req(wspq_pkg::REQ_ENQ, 32'hA5A5_5A5A, 10'd1023, 6'd63);
    send_req(wspq_pkg::REQ_ENQ, 32'h1234_5678, 10'd500, 6'd16);
    send_req(wspq_pkg::REQ_ENQ, 32'h8765_4321, 10'd500, 6'd16);
    send_req(wspq_pkg::REQ_ENQ, 32'h5555_AAAA, 10'd1, 6'd1);
    send_req(wspq_pkg::REQ_RSVD, '1, '1, '1);
    send_req(wspq_pkg::REQ_QUERY, '0, '0, '0);
    repeat (7) send_req(wspq_pkg::REQ_DEQ, '1, '0, '0);
    send_req(wspq_pkg::REQ_ENQ, 32'hCAFE_F00D, 10'd999, 6'd31);
    send_req(wspq_pkg::REQ_DEQ, '0, '0, '0);

    // random fill and drain phases; fill phases run well past full
    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < 120; i++) rand_req(ph[0] ? 15 : 85);
      if (ph == 3) begin
        idle_sender();
        @(negedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
    end

    idle_sender();
    @(negedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/wspq_pkg.sv
sv/wspq_front.sv
sv/wspq_fifo.sv
sv/wspq_back.sv
sv/weighted_score_priority_queue.sv
dv/wspq_checker.sv
dv/tb_top.sv
